### rtl/dts_pkg.sv
package dts_pkg;

  localparam int NUM_VERTICES_DEF = 8;
  localparam int MAX_DEGREE_DEF   = 8;
  localparam int MAX_RES          = 8;

  localparam int KIND_W  = 2;
  localparam int VTX_W   = 3;
  localparam int TS_W    = 5;
  localparam int PRED_W  = 4;
  localparam int TREE_W  = 4;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 24;

  localparam logic [PRED_W-1:0] ROOT_PRED = 4'hF;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_RUN    = 2'd2
  } kind_t;

endpackage

### rtl/dfs_timestamp_engine.sv
// Depth-first search timestamp engine.
// Input stream (in_t*): one beat per command. in_tuser carries the kind (clear,
// append neighbor, run search), in_tdata the vertex and neighbor. Kind 3 is
// taken and dropped without a result.
// Output stream (out_t*): clear and append answer with one beat; out_tuser
// flags a rejected append (list full). A run answers with one beat per vertex
// 0..min(NUM_VERTICES,8)-1 carrying discovery and finish times, predecessor
// (-1 for a root) and the tree count; out_tlast marks the final beat.
// A run first performs the search, paced by the single read port of the
// adjacency memory and by the stack pops, then reads out the result beats
// one at a time.
// One command is worked at a time. After a run, in_tready rises the cycle
// after its last beat is taken; after clear or append it follows out_tready
// while the result beat waits. A stalled receiver holds the output register
// and the run readout waits at that beat until it is taken.
// Reset empties every list and clears the output valid flag; the neighbor and
// timestamp memories need no clearing, since a run writes each vertex before
// it is reported.
module dfs_timestamp_engine
  import dts_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // vertex[2:0], neighbor[5:3], zero[7:6]
  input  logic [KIND_W-1:0] in_tuser,   // kind[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // out_vertex[2:0], discover_time[7:3],
                                        // finish_time[12:8], predecessor[16:13],
                                        // tree_total[20:17], zero[23:21]
  output logic              out_tuser,  // status
  output logic              out_tlast
);

  localparam int VW     = $clog2(NUM_VERTICES);
  localparam int DW     = $clog2(MAX_DEGREE + 1);
  localparam int EW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int ADEPTH = NUM_VERTICES * MAX_DEGREE;
  localparam int AW     = $clog2(ADEPTH);
  localparam int SW     = $clog2(NUM_VERTICES + 1);
  localparam int CW     = SW + VTX_W;
  localparam int NOUT   = (NUM_VERTICES < MAX_RES) ? NUM_VERTICES : MAX_RES;

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [DW-1:0] edge_idx;
    logic [DW-1:0] deg;
  } stk_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_APP   = 10'b0000000010,
    S_DEG   = 10'b0000000100,
    S_EDGE  = 10'b0000001000,
    S_NBR   = 10'b0000010000,
    S_POP   = 10'b0000100000,
    S_SWEEP = 10'b0001000000,
    S_RD    = 10'b0010000000,
    S_LD    = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  // memories
  logic [VW-1:0]     nbr_mem  [ADEPTH];
  logic [DW-1:0]     deg_mem  [NUM_VERTICES];
  logic [TS_W-1:0]   disc_mem [NUM_VERTICES];
  logic [TS_W-1:0]   fin_mem  [NUM_VERTICES];
  logic [PRED_W-1:0] pred_mem [NUM_VERTICES];
  stk_t              stk_mem  [NUM_VERTICES];

  logic [VW-1:0]     nbr_rdat_r;
  logic [DW-1:0]     deg_rdat_r;
  logic              deg_hit_r;
  logic [TS_W-1:0]   disc_rdat_r;
  logic [TS_W-1:0]   fin_rdat_r;
  logic [PRED_W-1:0] pred_rdat_r;
  stk_t              stk_rdat_r;

  // control state
  state_t              state_r, state_nxt;
  logic [NUM_VERTICES-1:0] deg_vld_r, deg_vld_nxt;
  logic [NUM_VERTICES-1:0] vis_r, vis_nxt;
  logic [VW-1:0]       cur_v_r, cur_v_nxt;
  logic [DW-1:0]       cur_e_r, cur_e_nxt;
  logic [DW-1:0]       cur_deg_r, cur_deg_nxt;
  logic [VW-1:0]       sp_r, sp_nxt;
  logic [SW-1:0]       sw_r, sw_nxt;
  logic [TS_W-1:0]     clk_cnt_r, clk_cnt_nxt;
  logic [TREE_W-1:0]   tree_r, tree_nxt;
  logic [VTX_W-1:0]    out_k_r, out_k_nxt;
  logic [VTX_W-1:0]    app_v_r, app_v_nxt;
  logic [VTX_W-1:0]    app_n_r, app_n_nxt;

  // output register
  logic                out_vld_r, out_vld_nxt;
  logic [VTX_W-1:0]    out_vtx_r, out_vtx_nxt;
  logic [TS_W-1:0]     out_disc_r, out_disc_nxt;
  logic [TS_W-1:0]     out_fin_r, out_fin_nxt;
  logic [PRED_W-1:0]   out_pred_r, out_pred_nxt;
  logic [TREE_W-1:0]   out_tree_r, out_tree_nxt;
  logic                out_st_r, out_st_nxt;
  logic                out_last_r, out_last_nxt;

  // memory ports
  logic                nbr_we;
  logic [AW-1:0]       nbr_wa, nbr_ra;
  logic [VW-1:0]       nbr_wd;
  logic                deg_we;
  logic [VW-1:0]       deg_wa, deg_ra;
  logic [DW-1:0]       deg_wd;
  logic                disc_we, fin_we;
  logic [VW-1:0]       disc_wa, fin_wa, out_ra;
  logic [TS_W-1:0]     disc_wd, fin_wd;
  logic [PRED_W-1:0]   pred_wd;
  logic                stk_we;
  logic [VW-1:0]       stk_ra;
  stk_t                stk_wd;

  logic                root_go;
  logic [VW-1:0]       root_v;
  logic                visit_go;
  logic [DW-1:0]       deg_eff;
  logic                app_ok;
  logic                in_fire;
  logic                out_fire;
  kind_t               in_kind;
  logic [VTX_W-1:0]    in_vertex;
  logic [VTX_W-1:0]    in_neighbor;

  assign in_kind     = kind_t'(in_tuser);
  assign in_vertex   = in_tdata[2:0];
  assign in_neighbor = in_tdata[5:3];

  assign in_tready = (state_r == S_IDLE) && (!out_vld_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_vld_r && out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_tree_r, out_pred_r, out_fin_r, out_disc_r, out_vtx_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  assign deg_eff = deg_hit_r ? deg_rdat_r : '0;
  assign app_ok  = (CW'(app_v_r) < CW'(NUM_VERTICES)) && (CW'(app_n_r) < CW'(NUM_VERTICES))
                   && (deg_eff < DW'(MAX_DEGREE));

  // read addresses
  assign nbr_ra = AW'(cur_v_r) * AW'(MAX_DEGREE) + AW'(cur_e_r[EW-1:0]);
  assign stk_ra = sp_r - 1'b1;
  assign out_ra = VW'(out_k_r);
  always_comb begin
    if (state_r == S_NBR) begin
      deg_ra = nbr_rdat_r;
    end else if (state_r == S_SWEEP) begin
      deg_ra = sw_r[VW-1:0];
    end else begin
      deg_ra = VW'(in_vertex);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    deg_vld_nxt  = deg_vld_r;
    vis_nxt      = vis_r;
    cur_v_nxt    = cur_v_r;
    cur_e_nxt    = cur_e_r;
    cur_deg_nxt  = cur_deg_r;
    sp_nxt       = sp_r;
    sw_nxt       = sw_r;
    clk_cnt_nxt  = clk_cnt_r;
    tree_nxt     = tree_r;
    out_k_nxt    = out_k_r;
    app_v_nxt    = app_v_r;
    app_n_nxt    = app_n_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_vtx_nxt  = out_vtx_r;
    out_disc_nxt = out_disc_r;
    out_fin_nxt  = out_fin_r;
    out_pred_nxt = out_pred_r;
    out_tree_nxt = out_tree_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;

    nbr_we  = 1'b0;
    nbr_wa  = AW'(app_v_r[VW-1:0]) * AW'(MAX_DEGREE) + AW'(deg_eff[EW-1:0]);
    nbr_wd  = VW'(app_n_r);
    deg_we  = 1'b0;
    deg_wa  = VW'(app_v_r);
    deg_wd  = deg_eff + 1'b1;
    disc_we = 1'b0;
    disc_wa = cur_v_r;
    disc_wd = '0;
    pred_wd = ROOT_PRED;
    fin_we  = 1'b0;
    fin_wa  = cur_v_r;
    fin_wd  = '0;
    stk_we  = 1'b0;
    stk_wd  = '{vtx: cur_v_r, edge_idx: cur_e_r, deg: cur_deg_r};
    root_go = 1'b0;
    root_v  = '0;
    visit_go = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          app_v_nxt = in_vertex;
          app_n_nxt = in_neighbor;
          case (in_kind)
            KIND_CLEAR: begin
              deg_vld_nxt  = '0;
              out_vld_nxt  = 1'b1;
              out_vtx_nxt  = '0;
              out_disc_nxt = '0;
              out_fin_nxt  = '0;
              out_pred_nxt = '0;
              out_tree_nxt = '0;
              out_st_nxt   = 1'b0;
              out_last_nxt = 1'b1;
            end
            KIND_APPEND: begin
              state_nxt = S_APP;
            end
            KIND_RUN: begin
              vis_nxt     = '0;
              clk_cnt_nxt = '0;
              sw_nxt      = '0;
              if (CW'(in_vertex) < CW'(NUM_VERTICES)) begin
                tree_nxt = TREE_W'(1);
                root_go  = 1'b1;
                root_v   = VW'(in_vertex);
              end else begin
                tree_nxt  = '0;
                state_nxt = S_SWEEP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_APP: begin
        if (app_ok) begin
          nbr_we = 1'b1;
          deg_we = 1'b1;
          deg_vld_nxt[VW'(app_v_r)] = 1'b1;
        end
        out_vld_nxt  = 1'b1;
        out_vtx_nxt  = '0;
        out_disc_nxt = '0;
        out_fin_nxt  = '0;
        out_pred_nxt = '0;
        out_tree_nxt = '0;
        out_st_nxt   = !app_ok;
        out_last_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DEG: begin
        cur_deg_nxt = deg_eff;
        state_nxt   = S_EDGE;
      end
      S_EDGE: begin
        if (cur_e_r < cur_deg_r) begin
          // neighbor read is in flight at nbr_ra
          cur_e_nxt = cur_e_r + 1'b1;
          state_nxt = S_NBR;
        end else begin
          clk_cnt_nxt = clk_cnt_r + 1'b1;
          fin_we      = 1'b1;
          fin_wd      = clk_cnt_nxt;
          if (sp_r == '0) begin
            state_nxt = S_SWEEP;
          end else begin
            sp_nxt    = sp_r - 1'b1;
            state_nxt = S_POP;
          end
        end
      end
      S_NBR: begin
        if (!vis_r[nbr_rdat_r]) begin
          // push the parent and descend
          stk_we   = 1'b1;
          sp_nxt   = sp_r + 1'b1;
          visit_go = 1'b1;
          root_v   = nbr_rdat_r;
          pred_wd  = PRED_W'(cur_v_r);
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_POP: begin
        cur_v_nxt   = stk_rdat_r.vtx;
        cur_e_nxt   = stk_rdat_r.edge_idx;
        cur_deg_nxt = stk_rdat_r.deg;
        state_nxt   = S_EDGE;
      end
      S_SWEEP: begin
        if (sw_r == SW'(NUM_VERTICES)) begin
          out_k_nxt = '0;
          state_nxt = S_RD;
        end else begin
          sw_nxt = sw_r + 1'b1;
          if (!vis_r[sw_r[VW-1:0]]) begin
            tree_nxt = tree_r + 1'b1;
            root_go  = 1'b1;
            root_v   = sw_r[VW-1:0];
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        out_vld_nxt  = 1'b1;
        out_vtx_nxt  = out_k_r;
        out_disc_nxt = disc_rdat_r;
        out_fin_nxt  = fin_rdat_r;
        out_pred_nxt = pred_rdat_r;
        out_tree_nxt = tree_r;
        out_st_nxt   = 1'b0;
        out_last_nxt = (out_k_r == VTX_W'(NOUT - 1));
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (out_fire) begin
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            out_k_nxt = out_k_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // discover a vertex: new tree root or a freshly reached neighbor
    if (root_go) begin
      sp_nxt = '0;
    end
    if (root_go || visit_go) begin
      vis_nxt[root_v] = 1'b1;
      clk_cnt_nxt     = clk_cnt_nxt + 1'b1;
      disc_we         = 1'b1;
      disc_wa         = root_v;
      disc_wd         = clk_cnt_nxt;
      cur_v_nxt       = root_v;
      cur_e_nxt       = '0;
      state_nxt       = S_DEG;
    end
  end

  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_wa] <= nbr_wd;
    end
    nbr_rdat_r <= nbr_mem[nbr_ra];
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_rdat_r <= deg_mem[deg_ra];
    deg_hit_r  <= deg_vld_r[deg_ra];
    if (disc_we) begin
      disc_mem[disc_wa] <= disc_wd;
      pred_mem[disc_wa] <= pred_wd;
    end
    if (fin_we) begin
      fin_mem[fin_wa] <= fin_wd;
    end
    disc_rdat_r <= disc_mem[out_ra];
    fin_rdat_r  <= fin_mem[out_ra];
    pred_rdat_r <= pred_mem[out_ra];
    if (stk_we) begin
      stk_mem[sp_r] <= stk_wd;
    end
    stk_rdat_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      deg_vld_r <= '0;
      vis_r     <= '0;
      sp_r      <= '0;
      sw_r      <= '0;
      clk_cnt_r <= '0;
      tree_r    <= '0;
      out_k_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      deg_vld_r <= deg_vld_nxt;
      vis_r     <= vis_nxt;
      sp_r      <= sp_nxt;
      sw_r      <= sw_nxt;
      clk_cnt_r <= clk_cnt_nxt;
      tree_r    <= tree_nxt;
      out_k_r   <= out_k_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_v_r    <= cur_v_nxt;
    cur_e_r    <= cur_e_nxt;
    cur_deg_r  <= cur_deg_nxt;
    app_v_r    <= app_v_nxt;
    app_n_r    <= app_n_nxt;
    out_vtx_r  <= out_vtx_nxt;
    out_disc_r <= out_disc_nxt;
    out_fin_r  <= out_fin_nxt;
    out_pred_r <= out_pred_nxt;
    out_tree_r <= out_tree_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### dv/dfs_search_checker.sv
`timescale 1ns / 100ps

module dfs_search_checker
  import dts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [KIND_W-1:0] in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic              out_tuser,
  input  logic              out_tlast,
  output int                fail_count,
  output int                pending
);

  localparam int NV = NUM_VERTICES_DEF;
  localparam int MD = MAX_DEGREE_DEF;

  typedef struct packed {
    logic [VTX_W-1:0]  vtx;
    logic [TS_W-1:0]   disc;
    logic [TS_W-1:0]   fin;
    logic [PRED_W-1:0] pred;
    logic [TREE_W-1:0] trees;
    logic              status;
    logic              last;
  } report_t;

  report_t report_q[$];

  // shadow of the graph and of the search state
  logic [VTX_W-1:0]  adj_list [NV][MD];
  int                degree [NV];
  logic              seen [NV];
  logic [TS_W-1:0]   disc_mem [NV];
  logic [TS_W-1:0]   fin_mem [NV];
  logic [PRED_W-1:0] pred_mem [NV];
  int                stack_vtx [NV];
  int                stack_edge [NV];
  logic [TS_W-1:0]   stamp;
  logic [TREE_W-1:0] trees;

  function automatic report_t plain_ack(input logic status);
    report_t r;
    r = '0;
    r.status = status;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic walk_tree(input int root);
    int depth;
    int top;
    int u;
    int v;
    seen[root]     = 1'b1;
    pred_mem[root] = ROOT_PRED;
    stamp          = stamp + 1'b1;
    disc_mem[root] = stamp;
    stack_vtx[0]   = root;
    stack_edge[0]  = 0;
    depth          = 1;
    while (depth > 0) begin
      top = depth - 1;
      u   = stack_vtx[top];
      if (stack_edge[top] < degree[u]) begin
        v = int'(adj_list[u][stack_edge[top]]);
        stack_edge[top]++;
        if (!seen[v] && depth < NV) begin
          seen[v]           = 1'b1;
          pred_mem[v]       = PRED_W'(u);
          stamp             = stamp + 1'b1;
          disc_mem[v]       = stamp;
          stack_vtx[depth]  = v;
          stack_edge[depth] = 0;
          depth++;
        end
      end else begin
        stamp      = stamp + 1'b1;
        fin_mem[u] = stamp;
        depth--;
      end
    end
  endtask

  task automatic predict_command(input logic [KIND_W-1:0] kind, input logic [VTX_W-1:0] vtx,
                                 input logic [VTX_W-1:0] nb);
    report_t r;
    case (kind)
      KIND_CLEAR: begin
        foreach (degree[i]) degree[i] = 0;
        report_q.push_back(plain_ack(1'b0));
      end
      KIND_APPEND: begin
        if (degree[vtx] < MD) begin
          adj_list[vtx][degree[vtx]] = nb;
          degree[vtx]++;
          report_q.push_back(plain_ack(1'b0));
        end else begin
          report_q.push_back(plain_ack(1'b1));
        end
      end
      KIND_RUN: begin
        foreach (seen[i]) seen[i] = 1'b0;
        stamp = '0;
        trees = TREE_W'(1);
        walk_tree(int'(vtx));
        for (int i = 0; i < NV; i++) begin
          if (!seen[i]) begin
            trees = trees + 1'b1;
            walk_tree(i);
          end
        end
        for (int i = 0; i < MAX_RES && i < NV; i++) begin
          r        = '0;
          r.vtx    = VTX_W'(i);
          r.disc   = disc_mem[i];
          r.fin    = fin_mem[i];
          r.pred   = pred_mem[i];
          r.trees  = trees;
          r.last   = (i == NV - 1 || i == MAX_RES - 1);
          report_q.push_back(r);
        end
      end
      default: ;  // spare kind: dropped silently
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      report_q.delete();
      foreach (degree[i]) degree[i] = 0;
      stamp = '0;
      trees = '0;
    end else begin
      // retire the result beat first; a command's results never share its accept edge
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("result beat with nothing outstanding: tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("out_vertex", int'(want.vtx), int'(out_tdata[2:0]));
          check_field("discover_time", int'(want.disc), int'(out_tdata[7:3]));
          check_field("finish_time", int'(want.fin), int'(out_tdata[12:8]));
          check_field("predecessor", int'($signed(want.pred)), int'($signed(out_tdata[16:13])));
          check_field("tree_total", int'(want.trees), int'(out_tdata[20:17]));
          check_field("pad", 0, int'(out_tdata[23:21]));
          check_field("status", int'(want.status), int'(out_tuser));
          check_field("last", int'(want.last), int'(out_tlast));
        end
      end
      if (in_tvalid && in_tready)
        predict_command(in_tuser, in_tdata[2:0], in_tdata[5:3]);
    end
    pending = report_q.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dts_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 185;
  localparam int STALL_LIMIT  = 5000;
  localparam int IDLE_PCT     = 22;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic [KIND_W-1:0] in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              out_tlast;

  int                fail_count;
  int                pending;
  int                quiet_cycles;
  bit                calm;

  dfs_timestamp_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dfs_search_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("dfs_timestamp_engine: mismatch");
      $finish;
    end
  end

  function automatic logic [VTX_W-1:0] rnd_vtx();
    return VTX_W'($urandom_range(0, 7));
  endfunction

  // enter and leave at a falling edge; tvalid stays high for a back-to-back beat
  task automatic push_command(input logic [KIND_W-1:0] kind, input logic [VTX_W-1:0] vtx,
                              input logic [VTX_W-1:0] nb);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, nb, vtx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int               sent;
    logic [VTX_W-1:0] hot;
    int               n_append;
    int               n_run;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    calm         = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, self loop, full list, spare kind, empty graph
    push_command(KIND_CLEAR, 3'd0, 3'd0);
    push_command(KIND_APPEND, 3'd0, 3'd7);
    push_command(KIND_APPEND, 3'd7, 3'd0);
    push_command(KIND_APPEND, 3'd5, 3'd5);
    for (int i = 0; i < MAX_DEGREE_DEF + 1; i++)
      push_command(KIND_APPEND, 3'd3, VTX_W'(7 - (i % 8)));
    push_command(KIND_SPARE, 3'd7, 3'd7);
    push_command(KIND_RUN, 3'd0, 3'd0);
    push_command(KIND_RUN, 3'd7, 3'd7);
    drain_results();
    push_command(KIND_CLEAR, 3'd7, 3'd7);
    push_command(KIND_RUN, 3'd4, 3'd0);

    // random graphs: clear, build with a favored owner, then search; runs and spare kinds are mixed into the build
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 80 && sent < 130);
      push_command(KIND_CLEAR, rnd_vtx(), rnd_vtx());
      sent++;
      hot      = rnd_vtx();
      n_append = $urandom_range(2, 22);
      for (int i = 0; i < n_append; i++) begin
        if ($urandom_range(0, 99) < 6)
          push_command(KIND_SPARE, rnd_vtx(), rnd_vtx());
        push_command(KIND_APPEND, ($urandom_range(0, 2) == 0) ? hot : rnd_vtx(),
                     rnd_vtx());
        sent++;
        if ($urandom_range(0, 99) < 12) begin
          push_command(KIND_RUN, rnd_vtx(), rnd_vtx());
          sent++;
        end
      end
      n_run = $urandom_range(1, 3);
      for (int i = 0; i < n_run; i++) begin
        push_command(KIND_RUN, rnd_vtx(), rnd_vtx());
        sent++;
      end
      if ($urandom_range(0, 3) == 0)
        drain_results();
    end
    calm = 1'b0;

    drain_results();
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("dfs_timestamp_engine: match");
    else
      $display("dfs_timestamp_engine: mismatch");
    $finish;
  end

endmodule
